### rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define CHK_ALWAYS(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("check failed: label");

// implication checked on every rising edge outside reset
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("check failed: label");

// next-cycle implication checked outside reset
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("check failed: label");

`endif

### rtl/ufd_pkg.sv
// types, constants and helpers of the form decoder with line-end normalization
// no dependencies
`timescale 1ns / 1ps

package ufd_pkg;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	// decoded bytes held by one queue entry
	localparam int ENTRY_BYTES = 3;

	typedef enum logic [1:0] {
		PH_NONE  = 2'd0,
		PH_PCT   = 2'd1,
		PH_DIGIT = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		SKIP_NONE = 2'd0,
		SKIP_LF   = 2'd1,
		SKIP_CR   = 2'd2
	} skip_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       run_last;
		logic       string_end;
	} out_item_t;

	// decoded bytes of one transaction, handed from front to back
	typedef struct packed {
		logic [ENTRY_BYTES-1:0][7:0] bytes;
		logic [1:0]                  count;
		logic                        last;
	} entry_t;

	// {valid, value}
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h61 + 8'd10)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h41 + 8'd10)};
		end
		return r;
	endfunction

endpackage

### rtl/ufd_front.sv
// front part: accepts raw characters, resolves escapes and '+', cuts at a decoded zero
// depends on ufd_pkg
`timescale 1ns / 1ps

module ufd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  ufd_pkg::in_item_t item,
	output logic              item_stall,
	input  logic              q_full,
	output logic              push,
	output ufd_pkg::entry_t   push_entry
);

	ufd_pkg::phase_t phase_q, phase_d;
	logic [7:0]      held_q, held_d;
	logic            trunc_q, trunc_d;

	logic [ufd_pkg::ENTRY_BYTES-1:0][7:0] d;
	logic [1:0]  n;
	logic [4:0]  hc;
	logic [4:0]  hh;
	logic        do_plain;
	logic        found;
	logic        accept;
	logic [7:0]  c;

	assign item_stall = q_full;
	assign accept     = item_valid && !q_full;
	assign c          = item.in_byte;

	always_comb begin
		d        = '0;
		n        = 2'd0;
		phase_d  = phase_q;
		held_d   = held_q;
		trunc_d  = trunc_q;
		do_plain = 1'b0;
		found    = 1'b0;
		hc       = ufd_pkg::hex_digit(c);
		hh       = ufd_pkg::hex_digit(held_q);
		if (!trunc_q) begin
			case (phase_q)
				ufd_pkg::PH_DIGIT: begin
					if (hc[4]) begin
						d[n] = {hh[3:0], hc[3:0]};
						n    = n + 2'd1;
					end else begin
						d[n]     = ufd_pkg::CH_PCT;
						n        = n + 2'd1;
						d[n]     = held_q;
						n        = n + 2'd1;
						do_plain = 1'b1;
					end
					phase_d = ufd_pkg::PH_NONE;
					held_d  = 8'd0;
				end
				ufd_pkg::PH_PCT: begin
					if (hc[4]) begin
						phase_d = ufd_pkg::PH_DIGIT;
						held_d  = c;
					end else begin
						d[n]     = ufd_pkg::CH_PCT;
						n        = n + 2'd1;
						phase_d  = ufd_pkg::PH_NONE;
						do_plain = 1'b1;
					end
				end
				default: begin
					do_plain = 1'b1;
				end
			endcase
			if (do_plain) begin
				if (c == ufd_pkg::CH_PLUS) begin
					d[n] = ufd_pkg::CH_SPACE;
					n    = n + 2'd1;
				end else if (c == ufd_pkg::CH_PCT) begin
					phase_d = ufd_pkg::PH_PCT;
				end else begin
					d[n] = c;
					n    = n + 2'd1;
				end
			end
			// flush a pending escape literally at the end of the string
			if (item.in_last) begin
				if (phase_d == ufd_pkg::PH_PCT) begin
					d[n] = ufd_pkg::CH_PCT;
					n    = n + 2'd1;
				end else if (phase_d == ufd_pkg::PH_DIGIT) begin
					d[n] = ufd_pkg::CH_PCT;
					n    = n + 2'd1;
					d[n] = held_d;
					n    = n + 2'd1;
				end
			end
			// decoded zero ends the string
			for (int i = 0; i < ufd_pkg::ENTRY_BYTES; i++) begin
				if (!found && 2'(i) < n && d[i] == 8'd0) begin
					found = 1'b1;
					n     = 2'(i);
				end
			end
			if (found) begin
				trunc_d = 1'b1;
				phase_d = ufd_pkg::PH_NONE;
				held_d  = 8'd0;
			end
		end
		if (item.in_last) begin
			phase_d = ufd_pkg::PH_NONE;
			held_d  = 8'd0;
			trunc_d = 1'b0;
		end
	end

	assign push             = accept && (n != 2'd0 || item.in_last);
	assign push_entry.bytes = d;
	assign push_entry.count = n;
	assign push_entry.last  = item.in_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ufd_pkg::PH_NONE;
			held_q  <= 8'd0;
			trunc_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			held_q  <= held_d;
			trunc_q <= trunc_d;
		end
	end

endmodule

### rtl/ufd_queue.sv
// short queue of decoded entries between front and back
// depends on ufd_pkg
`timescale 1ns / 1ps

module ufd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ufd_pkg::entry_t push_entry,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output ufd_pkg::entry_t head
);

	ufd_pkg::entry_t                   mem_q [ufd_pkg::QUEUE_DEPTH];
	logic [ufd_pkg::QUEUE_AW-1:0]      wr_q;
	logic [ufd_pkg::QUEUE_AW-1:0]      rd_q;
	logic [ufd_pkg::QUEUE_CW-1:0]      cnt_q;

	assign full       = cnt_q == ufd_pkg::QUEUE_CW'(ufd_pkg::QUEUE_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### rtl/ufd_back.sv
// back part: folds CR, CRLF and LFCR into LF and sends up to three results per transaction
// depends on ufd_pkg
`timescale 1ns / 1ps

module ufd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  ufd_pkg::entry_t    head,
	output logic               pop,
	output logic               res_valid,
	output ufd_pkg::out_item_t res,
	input  logic               res_stall
);

	ufd_pkg::skip_t     skip_q, sp;
	logic [1:0]         idx_q;
	logic               out_valid_q;
	ufd_pkg::out_item_t out_q;

	logic [ufd_pkg::ENTRY_BYTES-1:0][7:0] r;
	logic [1:0] nr;
	logic [1:0] n_out;
	logic       marker;
	logic       load;
	logic       fin;
	logic [7:0] b;

	always_comb begin
		sp = skip_q;
		r  = '0;
		nr = 2'd0;
		b  = 8'd0;
		for (int i = 0; i < ufd_pkg::ENTRY_BYTES; i++) begin
			if (2'(i) < head.count) begin
				b = head.bytes[i];
				if (sp == ufd_pkg::SKIP_LF && b == ufd_pkg::CH_LF) begin
					sp = ufd_pkg::SKIP_NONE;
				end else if (sp == ufd_pkg::SKIP_CR && b == ufd_pkg::CH_CR) begin
					sp = ufd_pkg::SKIP_NONE;
				end else begin
					sp = ufd_pkg::SKIP_NONE;
					if (b == ufd_pkg::CH_CR) begin
						r[nr] = ufd_pkg::CH_LF;
						sp    = ufd_pkg::SKIP_LF;
					end else if (b == ufd_pkg::CH_LF) begin
						r[nr] = ufd_pkg::CH_LF;
						sp    = ufd_pkg::SKIP_CR;
					end else begin
						r[nr] = b;
					end
					nr = nr + 2'd1;
				end
			end
		end
	end

	assign marker = head.last && nr == 2'd0;
	assign n_out  = marker ? 2'd1 : nr;
	assign load   = head_valid && (!out_valid_q || !res_stall);
	assign fin    = n_out != 2'd0 && idx_q == n_out - 2'd1;
	assign pop    = load && (n_out == 2'd0 || fin);

	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_ff @(posedge clk) begin
		if (load && n_out != 2'd0) begin
			out_q.out_byte   <= marker ? 8'd0 : r[idx_q];
			out_q.has_byte   <= !marker;
			out_q.run_last   <= fin;
			out_q.string_end <= fin && head.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q      <= ufd_pkg::SKIP_NONE;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load && n_out != 2'd0) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				idx_q  <= 2'd0;
				skip_q <= head.last ? ufd_pkg::SKIP_NONE : sp;
			end else if (load) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

endmodule

### rtl/url_form_decoder_eol_normalizer.sv
// Form-encoded text decoder with line-end normalization, top level.
// Channels: item (raw character plus in_last) and res (decoded results),
// both valid/stall; a transaction moves on a rising edge with valid high
// and stall low. Each raw character yields zero to three results; the
// last result of a transaction carries run_last, the last of a string also
// string_end, and an in_last transaction with nothing to send yields one
// bare end marker (has_byte low).
// A taken transaction is queued; the back end registers its results.
// Throughput: one transaction per cycle while each yields at most one
// result and res_stall is low; one with more holds the back end until all
// are sent, one with none (swallowed partner of a line end) is popped
// alone. The output register sends one result a cycle while res_stall is
// low; the four-entry queue between the decode front and the normalizing
// back absorbs the bursts. Reset clears the escape, truncation and
// line-end state, the queue and the output valid. While res_stall is high
// the result holds, the queue fills and item_stall rises once it is full.
// depends on ufd_pkg, ufd_front, ufd_queue, ufd_back
`timescale 1ns / 1ps

module url_form_decoder_eol_normalizer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  ufd_pkg::in_item_t  item,
	output logic               res_valid,
	input  logic               res_stall,
	output ufd_pkg::out_item_t res
);

	logic            q_full;
	logic            push;
	logic            pop;
	logic            head_valid;
	ufd_pkg::entry_t push_entry;
	ufd_pkg::entry_t head;

	ufd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_stall (item_stall),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	ufd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	ufd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.res_valid  (res_valid),
		.res        (res),
		.res_stall  (res_stall)
	);

endmodule

### rtl/ufd_checker.sv
// port-level checks of the decoder top level, attached by bind
// depends on ufd_pkg, assert_macros.svh and url_form_decoder_eol_normalizer
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ufd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_stall,
	input ufd_pkg::out_item_t res
);

	// stalled result holds
	`CHK_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(res))

	// end of string closes the transaction's run
	`CHK_IMPLY(a_end_is_run_last, clk, arst_n, res_valid && res.string_end, res.run_last)

	// bare end marker only as the final result and with a zero byte
	`CHK_IMPLY(a_marker_form, clk, arst_n, res_valid && !res.has_byte,
		res.string_end && res.out_byte == 8'd0)

	// decoded zero never reaches the output
	`CHK_ALWAYS(a_no_zero_byte, clk, arst_n, !(res_valid && res.has_byte && res.out_byte == 8'd0))

	// a carriage return never survives normalization
	`CHK_ALWAYS(a_no_cr, clk, arst_n, !(res_valid && res.has_byte && res.out_byte == ufd_pkg::CH_CR))

endmodule

bind url_form_decoder_eol_normalizer ufd_checker u_ufd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.res        (res)
);
